@@ hdl/mpq_pkg.sv @@
// mpq_pkg: shared types and constants of the multilevel priority ready queue
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;
   localparam int NumLevelsDefault = 32;
   localparam int NumItemsDefault  = 64;

   typedef enum logic [1:0] {
      KIND_ENQ   = 2'd0,
      KIND_REM   = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_QUEUED   = 2'd1,
      ST_NOTQUEUE = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;
endpackage
`default_nettype wire

@@ hdl/multilevel_priority_ready_queue.sv @@
// multilevel_priority_ready_queue: top level, one fifo list of ids per level
// depends on mpq_pkg
//
// Each request item goes from acceptance to a result held in the output
// register. The accepting edge also reads the item's level entry. The
// next edges read the item's links and its level's head and tail, write
// back, and read the head of the most urgent level. The last edge registers
// the result. One item is in flight at a time, so a new item is taken only
// once the last one's result is registered and any output stall has cleared.
// The link and level memories are single-write synchronous arrays; valid
// bits live in flip-flops. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_priority_ready_queue #(
   parameter int NUM_LEVELS = mpq_pkg::NumLevelsDefault,
   parameter int NUM_ITEMS  = mpq_pkg::NumItemsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // kind[1:0], item_id[7:2], priority_req[12:8]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // status, top_valid, top_item, level_count,
                                         // total_count
);
   import mpq_pkg::*;

   localparam int IW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int CW = $clog2(NUM_ITEMS + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_WRITE = 5'b00100,
      S_TOP   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // per-item memories
   logic [IW-1:0] next_mem [NUM_ITEMS];
   logic [IW-1:0] prev_mem [NUM_ITEMS];
   logic [LW-1:0] lvl_mem  [NUM_ITEMS];
   logic [NUM_ITEMS-1:0] queued_ff;
   // per-level memories
   logic [IW-1:0] head_mem [NUM_LEVELS];
   logic [IW-1:0] tail_mem [NUM_LEVELS];
   logic [CW-1:0] cnt_ff   [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] map_ff;
   logic [CW-1:0] total_ff;

   // request registers
   kind_type      kind_ff;
   logic [IW-1:0] id_ff;
   logic [LW-1:0] lvl_ff;
   logic [1:0]    stat_ff;

   // first stage read data
   logic [IW-1:0] rd_next_ff, rd_prev_ff;
   logic [LW-1:0] rd_lvl_ff;
   logic [IW-1:0] rd_head_ff, rd_tail_ff;
   logic [IW-1:0] top_rd_ff;

   logic          rv_ff;
   logic [23:0]   rd_ff;

   logic [IW-1:0] id_in;
   logic [LW-1:0] lvl_in;
   logic [7:0]    raw_id;
   logic [4:0]    raw_lvl;
   logic          take;

   assign raw_id  = {2'b00, req_tdata[7:2]};
   assign raw_lvl = req_tdata[12:8];
   always_comb begin
      id_in = IW'(32'(raw_id) % NUM_ITEMS);
      if (32'(raw_lvl) >= NUM_LEVELS) begin
         lvl_in = LW'(NUM_LEVELS - 1);
      end else begin
         lvl_in = LW'(raw_lvl);
      end
   end

   assign req_tready = (state_ff == S_IDLE) && (!rv_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   // level of the item under removal, stable once read
   logic [LW-1:0] il;
   assign il = rd_lvl_ff;

   // priority encoder over the nonempty bitmap
   logic          any;
   logic [LW-1:0] best;
   always_comb begin
      any  = 1'b0;
      best = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            any  = 1'b1;
            best = LW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (take) state_in = S_READ;
         S_READ:  state_in = S_WRITE;
         S_WRITE: state_in = S_TOP;
         S_TOP:   state_in = S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         queued_ff <= '0;
         map_ff    <= '0;
         total_ff  <= '0;
         rv_ff     <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rv_ff && rsp_tready) begin
            rv_ff <= 1'b0;
         end
         if (take) begin
            kind_ff   <= kind_type'(req_tdata[1:0]);
            id_ff     <= id_in;
            lvl_ff    <= lvl_in;
            rd_lvl_ff <= lvl_mem[id_in];
         end
         if (state_ff == S_READ) begin
            // reads of item entry and levels
            rd_next_ff <= next_mem[id_ff];
            rd_prev_ff <= prev_mem[id_ff];
            stat_ff    <= ST_DONE;
            if (kind_ff == KIND_ENQ && queued_ff[id_ff]) begin
               stat_ff <= ST_QUEUED;
            end else if (kind_ff == KIND_REM && !queued_ff[id_ff]) begin
               stat_ff <= ST_NOTQUEUE;
            end
         end
         if (state_ff == S_WRITE) begin
            if (kind_ff == KIND_ENQ && stat_ff == ST_DONE) begin
               if (cnt_ff[lvl_ff] == '0) begin
                  head_mem[lvl_ff] <= id_ff;
               end else begin
                  next_mem[rd_tail_ff] <= id_ff;
                  prev_mem[id_ff]      <= rd_tail_ff;
               end
               tail_mem[lvl_ff]  <= id_ff;
               lvl_mem[id_ff]    <= lvl_ff;
               queued_ff[id_ff]  <= 1'b1;
               cnt_ff[lvl_ff]    <= cnt_ff[lvl_ff] + 1'b1;
               total_ff          <= total_ff + 1'b1;
               map_ff[lvl_ff]    <= 1'b1;
            end else if (kind_ff == KIND_REM && stat_ff == ST_DONE) begin
               if (rd_head_ff == id_ff) begin
                  head_mem[il] <= rd_next_ff;
               end else begin
                  next_mem[rd_prev_ff] <= rd_next_ff;
               end
               if (rd_tail_ff == id_ff) begin
                  tail_mem[il] <= rd_prev_ff;
               end else begin
                  prev_mem[rd_next_ff] <= rd_prev_ff;
               end
               queued_ff[id_ff] <= 1'b0;
               if (cnt_ff[il] != '0) begin
                  cnt_ff[il] <= cnt_ff[il] - 1'b1;
               end
               if (total_ff != '0) begin
                  total_ff <= total_ff - 1'b1;
               end
               if (cnt_ff[il] <= CW'(1)) begin
                  map_ff[il] <= 1'b0;
               end
            end
         end
         if (state_ff == S_OUT) begin
            rv_ff <= 1'b1;
            rd_ff <= {1'b0,
                      7'(total_ff > CW'(127) ? 127 : total_ff),
                      7'(cnt_ff[lvl_ff] > CW'(127) ? 127 : cnt_ff[lvl_ff]),
                      any ? 6'(top_rd_ff) : 6'd0,
                      any,
                      stat_ff};
         end
      end
   end

   // level entry reads: enqueue needs the tail of the named level, removal the
   // head and tail of the item's level (read on the accepting edge)
   logic [LW-1:0] lsel;
   assign lsel = (kind_ff == KIND_REM) ? rd_lvl_ff : lvl_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_head_ff <= head_mem[lsel];
         rd_tail_ff <= tail_mem[lsel];
      end
      // sampled at the end of the lookup cycle, after write back has settled
      top_rd_ff <= head_mem[best];
   end
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// testbench for multilevel_priority_ready_queue: stream requests, check every response
// depends on mpq_pkg and the queue rtl; holds its own model of the per-level fifo lists
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import mpq_pkg::*;

   // packed from the top bit down, so status lands in the lowest bits
   typedef struct packed {
      logic       pad;
      logic [6:0] total_count;
      logic [6:0] level_count;
      logic [5:0] top_item;
      logic       top_valid;
      status_type st;
   } answer_type;

   typedef struct {
      kind_type   kind;
      logic [5:0] id;
      logic [4:0] lvl;
      bit         typed;
      answer_type ans;
   } stim_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;

   multilevel_priority_ready_queue dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // model of the queue: one fifo of ids per level
   logic [5:0] level_fifo[32][$];
   bit         is_queued[64];
   logic [4:0] level_of[64];
   int         queued_total;
   answer_type pending_answers[$];
   int         errors = 0;
   bit         quiet = 0;
   bit         holdoff = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic answer_type predict_answer(kind_type k, logic [5:0] id,
                                                 logic [4:0] lvl);
      answer_type a;
      int idx;
      logic [4:0] lv;
      a = '0;
      a.st = ST_DONE;
      if (k == KIND_ENQ) begin
         if (is_queued[id]) a.st = ST_QUEUED;
         else begin
            level_fifo[lvl].push_back(id);
            is_queued[id] = 1;
            level_of[id] = lvl;
            queued_total++;
         end
      end else if (k == KIND_REM) begin
         if (!is_queued[id]) a.st = ST_NOTQUEUE;
         else begin
            idx = -1;
            lv = level_of[id];
            for (int i = 0; i < level_fifo[lv].size(); i++)
               if (level_fifo[lv][i] == id) idx = i;
            level_fifo[lv].delete(idx);
            is_queued[id] = 0;
            queued_total--;
         end
      end
      for (int l = 31; l >= 0; l--)
         if (level_fifo[l].size() != 0) begin
            a.top_valid = 1;
            a.top_item = level_fifo[l][0];
         end
      a.level_count = 7'(level_fifo[lvl].size());
      a.total_count = 7'(queued_total);
      return a;
   endfunction

   // send one request, then record the predicted answer
   task automatic send_request(input stim_type s);
      answer_type a;
      req_tdata <= {3'b0, s.lvl, s.id, s.kind};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      a = predict_answer(s.kind, s.id, s.lvl);
      if (s.typed && a != s.ans) report_mismatch("directed row", a, s.ans);
      pending_answers.push_back(a);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      answer_type got, want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_answers.size() == 0) report_mismatch("unexpected item", 1, 0);
            else begin
               want = pending_answers.pop_front();
               if (got.st != want.st) report_mismatch("status", got.st, want.st);
               if (got.top_valid != want.top_valid)
                  report_mismatch("top_valid", got.top_valid, want.top_valid);
               if (got.top_item != want.top_item)
                  report_mismatch("top_item", got.top_item, want.top_item);
               if (got.level_count != want.level_count)
                  report_mismatch("level_count", got.level_count, want.level_count);
               if (got.total_count != want.total_count)
                  report_mismatch("total_count", got.total_count, want.total_count);
            end
         end
         if (holdoff) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            holdoff = 0;
            rsp_tready <= 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_tready <= 1;
         end else rsp_tready <= 1;
      end
   end

   function automatic stim_type mk(kind_type k, int id, int lvl, bit typed = 0,
                                   status_type st = ST_DONE, bit tv = 0, int ti = 0,
                                   int lc = 0, int tc = 0);
      stim_type s;
      s.kind = k; s.id = 6'(id); s.lvl = 5'(lvl); s.typed = typed;
      s.ans = '{1'b0, tc[6:0], lc[6:0], ti[5:0], tv, st};
      return s;
   endfunction

   initial begin
      stim_type directed[$];
      stim_type s;
      int n;
      logic [5:0] ids[$];
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed = '{
         mk(KIND_QUERY, 0, 0, 1, ST_DONE, 0, 0, 0, 0),
         mk(KIND_REM, 63, 31, 1, ST_NOTQUEUE, 0, 0, 0, 0),
         mk(KIND_ENQ, 63, 31, 1, ST_DONE, 1, 63, 1, 1),
         mk(KIND_ENQ, 63, 0, 1, ST_QUEUED, 1, 63, 0, 1),
         mk(KIND_ENQ, 0, 0, 1, ST_DONE, 1, 0, 1, 2),
         mk(KIND_ENQ, 5, 0), mk(KIND_ENQ, 7, 0), mk(KIND_ENQ, 42, 31),
         mk(KIND_OTHER, 21, 31), mk(KIND_REM, 5, 0), mk(KIND_REM, 0, 0),
         mk(KIND_ENQ, 21, 16), mk(KIND_REM, 7, 3), mk(KIND_REM, 63, 31),
         mk(KIND_QUERY, 0, 16), mk(KIND_REM, 42, 0), mk(KIND_REM, 21, 0),
         mk(KIND_QUERY, 63, 31, 1, ST_DONE, 0, 0, 0, 0)
      };
      foreach (directed[i]) send_request(directed[i]);
      // fill all 64 ids across levels while the response side holds off
      holdoff = 1;
      for (int i = 0; i < 64; i++) send_request(mk(KIND_ENQ, i, i % 32));
      for (int i = 0; i < 64; i++) send_request(mk(KIND_REM, (i * 37) % 64, 0));
      n = 0;
      while (n < 1500) begin
         if (n > 1350) quiet = 1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: s = mk(KIND_ENQ, $urandom_range(0, 63), $urandom_range(0, 31));
            4, 5, 6:    s = mk(KIND_REM, $urandom_range(0, 63), $urandom_range(0, 31));
            7:          s = mk(KIND_QUERY, $urandom_range(0, 63), $urandom_range(0, 31));
            8:          s = mk(KIND_OTHER, $urandom_range(0, 63), $urandom_range(0, 31));
            default: begin
               // mostly valid removals of queued ids
               ids.delete();
               foreach (is_queued[i]) if (is_queued[i]) ids.push_back(6'(i));
               s = mk(KIND_REM, ids.size() ? ids[$urandom_range(0, ids.size() - 1)] : 0,
                      $urandom_range(0, 31));
            end
         endcase
         send_request(s);
         n++;
      end
      req_tvalid <= 0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #6000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
hdl/mpq_pkg.sv
hdl/multilevel_priority_ready_queue.sv
tb/testbench.sv
